// ===== sv/pfqs_pkg.sv =====
// Shared constants, codes and types of the priority filter queue-to-stack block.
package pfqs_pkg;

  localparam int DEPTH = 128;                  // entries in the queue and in the stack
  localparam int IW    = $clog2(DEPTH);        // entry index width
  localparam int CW    = $clog2(DEPTH + 1);    // width of a pointer that can hold DEPTH

  localparam int ID_W   = 16;
  localparam int PRIO_W = 8;
  localparam int CNT_W  = 8;
  localparam int ST_W   = 2;
  localparam int ACT_W  = 2;

  localparam int SW = ID_W + PRIO_W;           // stack entry: {prio, id}
  localparam int QW = SW + 1;                  // queue entry: {moved, prio, id}

  localparam logic [ACT_W-1:0] ACT_ENQ  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_MOVE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_POP  = 2'd2;

  localparam logic [ST_W-1:0] STAT_OK     = 2'd0;
  localparam logic [ST_W-1:0] STAT_QFULL  = 2'd1;
  localparam logic [ST_W-1:0] STAT_SOVF   = 2'd2;
  localparam logic [ST_W-1:0] STAT_SEMPTY = 2'd3;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_WALK = 4'b0010,
    ST_POP  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  typedef struct packed {
    logic              valid;
    logic [ST_W-1:0]   status;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic [CNT_W-1:0]  count;
  } res_t;

endpackage

// ===== sv/priority_filter_queue_to_stack.sv =====
// Top level: stream ports, queue and stack memories, sequencer and output register.
//
// A linear arrival queue of (id, priority) entries feeds a stack. Each input transfer
// carries one operation in s_tuser and yields exactly one result transfer. Enqueue
// appends at the rear; the queue reports full after DEPTH appends since reset, since
// slots are never reused. Pop passes through an extra state for the registered read of
// the stack memory. Move walks the live part of the queue from front to rear: the walk
// reads one queue entry per cycle through the queue memory's registered read port, and
// one shared compare/push unit decides each entry, pushing qualifying entries onto the
// stack and marking them moved in the same memory. The block takes no new item while an
// operation is in progress. A finished result waits in the output register and the next
// operation may start meanwhile; if that operation finishes before the waiting result
// leaves, the sequencer holds its result and stays not ready until the output register
// frees up. No clearing pass is needed after reset.
module priority_filter_queue_to_stack (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [15:0] proc_id, [23:16] prio_in, [31:24] min_priority
  input  logic [31:0] s_tdata,
  // [1:0] action
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [1:0] status, [17:2] out_id, [25:18] out_priority, [33:26] moved_count, [39:34] zero
  output logic [39:0] m_tdata
);

  logic                      q_we;
  logic [pfqs_pkg::IW-1:0]   q_waddr;
  logic [pfqs_pkg::QW-1:0]   q_wdata;
  logic [pfqs_pkg::IW-1:0]   q_raddr;
  logic [pfqs_pkg::QW-1:0]   q_rdata;
  logic                      s_we;
  logic [pfqs_pkg::IW-1:0]   s_waddr;
  logic [pfqs_pkg::SW-1:0]   s_wdata;
  logic [pfqs_pkg::IW-1:0]   s_raddr;
  logic [pfqs_pkg::SW-1:0]   s_rdata;
  pfqs_pkg::res_t            res;
  logic                      res_take;
  logic [33:0]               out_data;

  // queue entries: {moved, prio, id}
  pfqs_ram #(.WIDTH(pfqs_pkg::QW), .DEPTH_P(pfqs_pkg::DEPTH)) u_queue (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  // stack entries: {prio, id}
  pfqs_ram #(.WIDTH(pfqs_pkg::SW), .DEPTH_P(pfqs_pkg::DEPTH)) u_stack (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  pfqs_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .action       (s_tuser),
    .proc_id      (s_tdata[15:0]),
    .prio_in      (s_tdata[23:16]),
    .min_priority (s_tdata[31:24]),
    .q_we         (q_we),
    .q_waddr      (q_waddr),
    .q_wdata      (q_wdata),
    .q_raddr      (q_raddr),
    .q_rdata      (q_rdata),
    .s_we         (s_we),
    .s_waddr      (s_waddr),
    .s_wdata      (s_wdata),
    .s_raddr      (s_raddr),
    .s_rdata      (s_rdata),
    .res          (res),
    .res_take     (res_take)
  );

  // Load the output register whenever it is empty or being drained this cycle.
  assign res_take = res.valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Payload needs no reset; hold it while the transfer is stalled.
  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data <= {res.count, res.prio, res.id, res.status};
    end
  end

  assign m_tdata = {6'd0, out_data};

endmodule

// ===== sv/pfqs_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
module pfqs_ram #(
  parameter int WIDTH   = 8,
  parameter int DEPTH_P = 16,
  parameter int AW      = $clog2(DEPTH_P)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH_P];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/pfqs_ctrl.sv =====
// Sequencer: decodes operations and walks the queue through one compare/push unit.
module pfqs_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pfqs_pkg::ACT_W-1:0]    action,
  input  logic [pfqs_pkg::ID_W-1:0]     proc_id,
  input  logic [pfqs_pkg::PRIO_W-1:0]   prio_in,
  input  logic [pfqs_pkg::PRIO_W-1:0]   min_priority,
  output logic                          q_we,
  output logic [pfqs_pkg::IW-1:0]       q_waddr,
  output logic [pfqs_pkg::QW-1:0]       q_wdata,
  output logic [pfqs_pkg::IW-1:0]       q_raddr,
  input  logic [pfqs_pkg::QW-1:0]       q_rdata,
  output logic                          s_we,
  output logic [pfqs_pkg::IW-1:0]       s_waddr,
  output logic [pfqs_pkg::SW-1:0]       s_wdata,
  output logic [pfqs_pkg::IW-1:0]       s_raddr,
  input  logic [pfqs_pkg::SW-1:0]       s_rdata,
  output pfqs_pkg::res_t                res,
  input  logic                          res_take
);

  localparam logic [pfqs_pkg::CW-1:0] FULL = pfqs_pkg::CW'(pfqs_pkg::DEPTH);

  pfqs_pkg::state_t state;

  logic [pfqs_pkg::CW-1:0]     tail;
  logic [pfqs_pkg::CW-1:0]     head;
  logic [pfqs_pkg::CW-1:0]     fill;
  logic [pfqs_pkg::CW-1:0]     issue;
  logic [pfqs_pkg::IW-1:0]     eval_idx;
  logic                        pend;
  logic                        lead;
  logic [pfqs_pkg::PRIO_W-1:0] minp;
  logic [pfqs_pkg::ST_W-1:0]   stat;
  logic [pfqs_pkg::ID_W-1:0]   rid;
  logic [pfqs_pkg::PRIO_W-1:0] rprio;
  logic [pfqs_pkg::CNT_W-1:0]  cnt;

  logic accept;
  logic old_moved;
  logic qualify;
  logic more;

  assign in_ready  = (state == pfqs_pkg::ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign old_moved = q_rdata[pfqs_pkg::QW-1];
  assign qualify   = pend && !old_moved && (q_rdata[pfqs_pkg::SW-1:pfqs_pkg::ID_W] >= minp);
  assign more      = (issue < tail);

  always_comb begin
    q_we    = 1'b0;
    q_waddr = eval_idx;
    q_wdata = {1'b1, q_rdata[pfqs_pkg::SW-1:0]};
    if (state == pfqs_pkg::ST_IDLE) begin
      q_we    = accept && (action == pfqs_pkg::ACT_ENQ) && (tail != FULL);
      q_waddr = tail[pfqs_pkg::IW-1:0];
      q_wdata = {1'b0, prio_in, proc_id};
    end else if (state == pfqs_pkg::ST_WALK) begin
      q_we = qualify;
    end
  end

  assign q_raddr = issue[pfqs_pkg::IW-1:0];
  assign s_we    = (state == pfqs_pkg::ST_WALK) && qualify && (fill != FULL);
  assign s_waddr = fill[pfqs_pkg::IW-1:0];
  assign s_wdata = q_rdata[pfqs_pkg::SW-1:0];
  assign s_raddr = pfqs_pkg::IW'(fill - pfqs_pkg::CW'(1));

  assign res.valid  = (state == pfqs_pkg::ST_DONE);
  assign res.status = stat;
  assign res.id     = rid;
  assign res.prio   = rprio;
  assign res.count  = cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pfqs_pkg::ST_IDLE;
      tail  <= '0;
      head  <= '0;
      fill  <= '0;
      pend  <= 1'b0;
    end else begin
      case (state)
        pfqs_pkg::ST_IDLE: begin
          if (accept) begin
            minp  <= min_priority;
            stat  <= pfqs_pkg::STAT_OK;
            rid   <= '0;
            rprio <= '0;
            cnt   <= '0;
            case (action)
              pfqs_pkg::ACT_ENQ: begin
                if (tail == FULL) begin
                  stat <= pfqs_pkg::STAT_QFULL;
                end else begin
                  tail <= tail + pfqs_pkg::CW'(1);
                end
                state <= pfqs_pkg::ST_DONE;
              end
              pfqs_pkg::ACT_MOVE: begin
                issue <= head;
                pend  <= 1'b0;
                lead  <= 1'b1;
                state <= pfqs_pkg::ST_WALK;
              end
              pfqs_pkg::ACT_POP: begin
                if (fill == '0) begin
                  stat  <= pfqs_pkg::STAT_SEMPTY;
                  state <= pfqs_pkg::ST_DONE;
                end else begin
                  fill  <= fill - pfqs_pkg::CW'(1);
                  state <= pfqs_pkg::ST_POP;
                end
              end
              default: begin
                state <= pfqs_pkg::ST_DONE;
              end
            endcase
          end
        end
        pfqs_pkg::ST_WALK: begin
          // issue the next read while the previous entry is evaluated
          pend <= more;
          if (more) begin
            issue    <= issue + pfqs_pkg::CW'(1);
            eval_idx <= issue[pfqs_pkg::IW-1:0];
          end
          if (pend) begin
            if (qualify) begin
              if (fill != FULL) begin
                fill <= fill + pfqs_pkg::CW'(1);
                if (cnt != pfqs_pkg::CNT_MAX) begin
                  cnt <= cnt + pfqs_pkg::CNT_W'(1);
                end
              end else begin
                stat <= pfqs_pkg::STAT_SOVF;
              end
            end
            // advance the front past the leading run of moved entries
            if (lead && (old_moved || qualify)) begin
              head <= pfqs_pkg::CW'(eval_idx) + pfqs_pkg::CW'(1);
            end else begin
              lead <= 1'b0;
            end
          end
          if (!pend && !more) begin
            state <= pfqs_pkg::ST_DONE;
          end
        end
        pfqs_pkg::ST_POP: begin
          rid   <= s_rdata[pfqs_pkg::ID_W-1:0];
          rprio <= s_rdata[pfqs_pkg::SW-1:pfqs_pkg::ID_W];
          state <= pfqs_pkg::ST_DONE;
        end
        pfqs_pkg::ST_DONE: begin
          if (res_take) begin
            state <= pfqs_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= pfqs_pkg::ST_IDLE;
        end
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= FULL)
    else $error("stack fill beyond depth");
  a_head_tail: assert property (@(posedge clk) disable iff (rst) head <= tail)
    else $error("queue front passed the rear");
  a_walk_ports: assert property (@(posedge clk) disable iff (rst)
      (q_we && state == pfqs_pkg::ST_WALK) |-> (q_waddr != q_raddr))
    else $error("flag write collides with walk read");
  a_pop_done: assert property (@(posedge clk) disable iff (rst)
      (state == pfqs_pkg::ST_POP) |=> (state == pfqs_pkg::ST_DONE))
    else $error("pop did not finish");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
      s_we |=> (fill == $past(fill) + pfqs_pkg::CW'(1)))
    else $error("push did not advance stack fill");

endmodule

// ===== tb/priority_filter_queue_to_stack_scoreboard.sv =====
// Scoreboard class and predictor state for the queue-to-stack testbench.
package pfqs_tb_pkg;
  import pfqs_pkg::*;

  localparam logic [ACT_W-1:0] ACT_NOP = 2'd3;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic [CNT_W-1:0]  count;
  } outcome_t;

  class queue_stack_scoreboard;
    logic [ID_W-1:0]   q_id    [DEPTH];
    logic [PRIO_W-1:0] q_prio  [DEPTH];
    bit                q_moved [DEPTH];
    logic [ID_W-1:0]   st_id   [DEPTH];
    logic [PRIO_W-1:0] st_prio [DEPTH];
    int unsigned       head;
    int unsigned       tail;
    int unsigned       fill;
    outcome_t          expected_q[$];
    int unsigned       errors;
    int unsigned       checked;
    int unsigned       n_enq, n_move, n_pop, n_nop;
    int unsigned       n_qfull, n_sempty, n_pushed, max_fill;

    function new();
      head     = 0;
      tail     = 0;
      fill     = 0;
      errors   = 0;
      checked  = 0;
      n_enq    = 0;
      n_move   = 0;
      n_pop    = 0;
      n_nop    = 0;
      n_qfull  = 0;
      n_sempty = 0;
      n_pushed = 0;
      max_fill = 0;
      foreach (q_moved[i]) q_moved[i] = 1'b0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Advance the predicted state by one accepted input transfer.
    function void note_input(logic [ACT_W-1:0] action, logic [ID_W-1:0] id,
                             logic [PRIO_W-1:0] prio, logic [PRIO_W-1:0] minp);
      outcome_t r;
      r = '0;
      case (action)
        ACT_ENQ: begin
          n_enq++;
          if (tail >= DEPTH) begin
            r.status = STAT_QFULL;
            n_qfull++;
          end else begin
            q_id[tail]    = id;
            q_prio[tail]  = prio;
            q_moved[tail] = 1'b0;
            tail++;
          end
        end
        ACT_MOVE: begin
          n_move++;
          for (int unsigned i = head; i < tail; i++) begin
            if (!q_moved[i] && q_prio[i] >= minp) begin
              if (fill < DEPTH) begin
                st_id[fill]   = q_id[i];
                st_prio[fill] = q_prio[i];
                fill++;
                n_pushed++;
                if (r.count != CNT_MAX) r.count = r.count + 1'b1;
              end else begin
                r.status = STAT_SOVF;
              end
              q_moved[i] = 1'b1;
            end
          end
          while (head < tail && q_moved[head]) head++;
          if (fill > max_fill) max_fill = fill;
        end
        ACT_POP: begin
          n_pop++;
          if (fill == 0) begin
            r.status = STAT_SEMPTY;
            n_sempty++;
          end else begin
            fill--;
            r.id   = st_id[fill];
            r.prio = st_prio[fill];
          end
        end
        default: n_nop++;
      endcase
      expected_q.push_back(r);
    endfunction

    // Compare one result transfer with the oldest prediction.
    function void check_result(logic [39:0] data);
      outcome_t got;
      outcome_t want;
      got.status = data[1:0];
      got.id     = data[17:2];
      got.prio   = data[25:18];
      got.count  = data[33:26];
      if (expected_q.size() == 0) begin
        errors++;
        $error("result transfer with no prediction pending: tdata=%h", data);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.status !== want.status) begin
        errors++;
        $error("status mismatch: expected %0d actual %0d", want.status, got.status);
      end
      if (got.id !== want.id) begin
        errors++;
        $error("out_id mismatch: expected %h actual %h", want.id, got.id);
      end
      if (got.prio !== want.prio) begin
        errors++;
        $error("out_priority mismatch: expected %h actual %h", want.prio, got.prio);
      end
      if (got.count !== want.count) begin
        errors++;
        $error("moved_count mismatch: expected %0d actual %0d", want.count, got.count);
      end
    endfunction
  endclass

endpackage

// ===== tb/priority_filter_queue_to_stack_tb.sv =====
// Testbench top: drives operations into the queue-to-stack block and checks every result.
module priority_filter_queue_to_stack_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pfqs_pkg::*;
  import pfqs_tb_pkg::*;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int ITEMS_PER_PHASE = 600;
  localparam int DRAIN_CYCLES    = DEPTH + 16;  // longest move plus handover slack

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;   // [15:0] proc_id, [23:16] prio_in, [31:24] min_priority
  logic [1:0]  s_tuser  = '0;   // [1:0] action
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;         // [1:0] status, [17:2] out_id, [25:18] out_priority,
                                // [33:26] moved_count, [39:34] zero

  int unsigned send_idle_pct = 37;
  int unsigned recv_idle_pct = 57;
  int unsigned cycle_count   = 0;

  queue_stack_scoreboard sb = new();

  priority_filter_queue_to_stack u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // Receiver: decide backpressure at the falling edge so it is stable at the next rising edge.
  always @(negedge clk) begin
    m_tready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
  end

  // Sample result transfers at the rising edge; the watchdog also lives here.
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, sb.pending());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Present one operation and hold it until the block takes the transfer.
  // Entered and left at a falling edge; valid stays high on exit so back-to-back
  // transfers never drop it within a time step.
  task automatic send_op(input logic [ACT_W-1:0] action, input logic [ID_W-1:0] id,
                         input logic [PRIO_W-1:0] prio, input logic [PRIO_W-1:0] minp);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {minp, prio, id};
    s_tuser  <= action;
    do @(posedge clk); while (!s_tready);
    sb.note_input(action, id, prio, minp);
    @(negedge clk);
  endtask

  // Random operation. Fill mode favors enqueue and move to build up a deep stack;
  // drain mode favors pop so the stack empties out and underflows now and then.
  task automatic send_random_op(input bit fill_mode);
    int unsigned       pick;
    logic [ACT_W-1:0]  action;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic [PRIO_W-1:0] minp;
    pick = $urandom_range(99);
    if (fill_mode) begin
      if (pick < 45)      action = ACT_ENQ;
      else if (pick < 75) action = ACT_MOVE;
      else if (pick < 97) action = ACT_POP;
      else                action = ACT_NOP;
    end else begin
      if (pick < 8)       action = ACT_ENQ;
      else if (pick < 25) action = ACT_MOVE;
      else if (pick < 95) action = ACT_POP;
      else                action = ACT_NOP;
    end
    id = ID_W'($urandom);
    // Mix in the priority extremes so thresholds hit ties at both ends.
    if ($urandom_range(7) == 0) prio = $urandom_range(1) ? '1 : '0;
    else                        prio = PRIO_W'($urandom);
    if ($urandom_range(7) == 0) minp = $urandom_range(1) ? '1 : '0;
    else                        minp = PRIO_W'($urandom);
    send_op(action, id, prio, minp);
  endtask

  initial begin
    bit fill_mode;
    fill_mode = 1'b1;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty stack and empty queue first, then field extremes and thresholds.
    send_op(ACT_POP,  16'h0000, 8'h00, 8'h00);  // pop on empty stack
    send_op(ACT_MOVE, 16'hFFFF, 8'hFF, 8'h00);  // move on empty queue
    send_op(ACT_NOP,  16'hFFFF, 8'hFF, 8'hFF);  // unused action code
    send_op(ACT_ENQ,  16'h0000, 8'h00, 8'hFF);
    send_op(ACT_ENQ,  16'hFFFF, 8'hFF, 8'h00);
    send_op(ACT_ENQ,  16'h1234, 8'h80, 8'h00);
    send_op(ACT_ENQ,  16'hA5A5, 8'h7F, 8'h00);
    send_op(ACT_MOVE, 16'h0000, 8'h00, 8'hFF);  // only the top priority moves
    send_op(ACT_MOVE, 16'h0000, 8'h00, 8'h80);  // tie at the threshold moves
    send_op(ACT_MOVE, 16'h0000, 8'h00, 8'h00);  // the rest, head advances to tail
    send_op(ACT_MOVE, 16'h0000, 8'h00, 8'h00);  // nothing left unmoved
    repeat (5) send_op(ACT_POP, 16'h0000, 8'h00, 8'h00);  // four entries, then empty
    send_op(ACT_ENQ,  16'h5A5A, 8'h01, 8'h00);
    send_op(ACT_MOVE, 16'h0000, 8'h00, 8'h02);  // below threshold, stays in queue
    send_op(ACT_POP,  16'h0000, 8'h00, 8'h00);
    send_op(ACT_MOVE, 16'h0000, 8'h00, 8'h01);
    send_op(ACT_POP,  16'h0000, 8'h00, 8'h00);

    // Random: receiver-heavy idling, then sender-heavy idling, then full rate.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 37;
          recv_idle_pct = 57;
        end
        1: begin
          send_idle_pct = 57;
          recv_idle_pct = 37;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 64 == 0) fill_mode = 1'($urandom_range(1));
        send_random_op(fill_mode);
      end
    end
    s_tvalid <= 1'b0;

    // Drain outstanding results, then watch for stray transfers.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d enqueues (%0d on a full queue), %0d moves pushing %0d entries,",
             sb.n_enq, sb.n_qfull, sb.n_move, sb.n_pushed);
    $display("%0d pops (%0d on an empty stack), %0d no-ops; stack peaked at %0d, %0d checked",
             sb.n_pop, sb.n_sempty, sb.n_nop, sb.max_fill, sb.checked);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== priority_filter_queue_to_stack.f =====
sv/pfqs_pkg.sv
sv/pfqs_ram.sv
sv/pfqs_ctrl.sv
sv/priority_filter_queue_to_stack.sv
tb/priority_filter_queue_to_stack_scoreboard.sv
tb/priority_filter_queue_to_stack_tb.sv
